@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the tilt drive rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define FPTD_ASSERT(lbl, clk_i, rstn_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
		else $error("fptd assertion failed");

// condition must never be seen outside reset
`define FPTD_NEVER(lbl, clk_i, rstn_i, cond) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) \
		else $error("fptd forbidden condition seen");

`endif

@@ rtl/core/fptd_pkg.sv @@
// package with widths, register map and shared types of the tilt drive
package fptd_pkg;

	localparam int DEF_SAMPLE_RATE_HZ = 100;
	localparam int DEF_SAMPLE_BITS    = 12;

	localparam int MUL_A_W = 22;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 64;
	localparam int LO_W    = 21;

	localparam int RATE_W   = 17;
	localparam int RECIP_W  = 22;
	localparam int FILT_W   = 20;
	localparam int ERR_W    = 21;
	localparam int DIFF_W   = ERR_W + 1;
	localparam int DERIV_W  = DIFF_W + RATE_W;
	localparam int INTEG_W  = 33;
	localparam int DUTY_W   = 17;

	localparam int TARGET_W = 19;
	localparam int GAIN_W   = 24;
	localparam int WEIGHT_W = 17;
	localparam int ILIM_W   = 32;
	localparam int DLIM_W   = 17;
	localparam int TILT_W   = 19;

	localparam int DATA_W     = 32;
	localparam int REG_ADDR_W = 5;
	localparam int OUT_DATA_W = ((2 * DUTY_W + 7) / 8) * 8;

	localparam int FILT_FRAC   = 16;
	localparam int ANGLE_SHIFT = 8;

	localparam logic [14:0]       ANGLE_SCALE = 15'd23827;
	localparam logic [WEIGHT_W-1:0] UNITY     = 17'd65536;

	localparam logic [TARGET_W-1:0] TARGET_RST = 19'd308374;
	localparam logic [GAIN_W-1:0]   GAIN_RST   = 24'd0;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd19661;
	localparam logic [ILIM_W-1:0]   ILIM_RST   = 32'd655360000;
	localparam logic [DLIM_W-1:0]   DLIM_RST   = 17'd13107;
	localparam logic [TILT_W-1:0]   TILT_RST   = 19'd51472;

	typedef enum logic [2:0] {
		REG_TARGET,
		REG_KP,
		REG_KI,
		REG_KD,
		REG_WEIGHT,
		REG_ILIM,
		REG_DLIM,
		REG_TILT
	} reg_idx_t;

	typedef struct packed {
		logic [TARGET_W-1:0]        target;
		logic signed [GAIN_W-1:0]   kp;
		logic signed [GAIN_W-1:0]   ki;
		logic signed [GAIN_W-1:0]   kd;
		logic [WEIGHT_W-1:0]        weight;
		logic [ILIM_W-1:0]          ilim;
		logic [DLIM_W-1:0]          dlim;
		logic [TILT_W-1:0]          tilt;
	} cfg_t;

	typedef struct packed {
		logic                       en;
		logic                       clr;
		logic                       rnd;
		logic                       hi;
		logic signed [MUL_A_W-1:0]  a;
		logic signed [MUL_B_W-1:0]  b;
	} mac_ctl_t;

endpackage

@@ rtl/core/filtered_pid_tilt_drive.sv @@
// top level of the filtered pid tilt drive
// usage:
//   configuration goes through the apb port, one register every four bytes, pready
//   always high; the user must write registers only while no item is in flight; the block does not enforce it.
//   s_tdata carries one raw angle sample in its low SAMPLE_BITS bits.
//   m_tdata carries drive_right in bits 16:0 and drive_left in bits 33:17,
//   m_tuser carries the tilt cutoff flag.
// timing:
//   one item is in work at a time on one shared 22 x 25 multiply-accumulate unit;
//   the result is registered in the output register when the sequence ends, and the next
//   item is taken in the idle state that follows. the sequence is eleven multiplies
//   with their pipeline waits.
// reset:
//   registers return to their reset values and filter, error and integral clear.
// stall:
//   a finished result waits in the output register while m_tready is low; the next
//   item is still taken and worked on, and its sequence holds at its last step with
//   s_tready low until the waiting result is taken.
module filtered_pid_tilt_drive #(
	parameter int SAMPLE_RATE_HZ = fptd_pkg::DEF_SAMPLE_RATE_HZ,
	parameter int SAMPLE_BITS    = fptd_pkg::DEF_SAMPLE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fptd_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [fptd_pkg::DATA_W-1:0]     pwdata,
	output logic [fptd_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// angle_sample
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// drive_right, drive_left
	output logic [fptd_pkg::OUT_DATA_W-1:0] m_tdata,
	// tilt_cutoff
	output logic [0:0]                      m_tuser
);
	import fptd_pkg::*;

	cfg_t                    cfg;
	mac_ctl_t                ctl;
	logic signed [ACC_W-1:0] acc;
	logic [DUTY_W-1:0]       right;
	logic [DUTY_W-1:0]       left;
	logic                    cut;

	fptd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fptd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.acc    (acc)
	);

	fptd_seq #(
		.SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.sample  (s_tdata[SAMPLE_BITS-1:0]),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.right   (right),
		.left    (left),
		.cut     (cut),
		.acc     (acc),
		.ctl     (ctl)
	);

	assign m_tdata = {{(OUT_DATA_W - 2 * DUTY_W){1'b0}}, left, right};
	assign m_tuser = cut;

endmodule

@@ rtl/core/fptd_regs.sv @@
// apb configuration registers of the tilt drive
module fptd_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fptd_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [fptd_pkg::DATA_W-1:0]     pwdata,
	output logic [fptd_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	output fptd_pkg::cfg_t                  cfg
);
	import fptd_pkg::*;

	logic [TARGET_W-1:0] target_q;
	logic [GAIN_W-1:0]   kp_q;
	logic [GAIN_W-1:0]   ki_q;
	logic [GAIN_W-1:0]   kd_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [ILIM_W-1:0]   ilim_q;
	logic [DLIM_W-1:0]   dlim_q;
	logic [TILT_W-1:0]   tilt_q;
	reg_idx_t            idx;
	logic                wr;

	assign idx    = reg_idx_t'(paddr[REG_ADDR_W-1:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			kp_q     <= GAIN_RST;
			ki_q     <= GAIN_RST;
			kd_q     <= GAIN_RST;
			weight_q <= WEIGHT_RST;
			ilim_q   <= ILIM_RST;
			dlim_q   <= DLIM_RST;
			tilt_q   <= TILT_RST;
		end else if (wr) begin
			unique case (idx)
				REG_TARGET: target_q <= pwdata[TARGET_W-1:0];
				REG_KP:     kp_q     <= pwdata[GAIN_W-1:0];
				REG_KI:     ki_q     <= pwdata[GAIN_W-1:0];
				REG_KD:     kd_q     <= pwdata[GAIN_W-1:0];
				REG_WEIGHT: weight_q <= pwdata[WEIGHT_W-1:0];
				REG_ILIM:   ilim_q   <= pwdata[ILIM_W-1:0];
				REG_DLIM:   dlim_q   <= pwdata[DLIM_W-1:0];
				REG_TILT:   tilt_q   <= pwdata[TILT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TARGET: prdata = DATA_W'(target_q);
			REG_KP:     prdata = DATA_W'(kp_q);
			REG_KI:     prdata = DATA_W'(ki_q);
			REG_KD:     prdata = DATA_W'(kd_q);
			REG_WEIGHT: prdata = DATA_W'(weight_q);
			REG_ILIM:   prdata = DATA_W'(ilim_q);
			REG_DLIM:   prdata = DATA_W'(dlim_q);
			REG_TILT:   prdata = DATA_W'(tilt_q);
		endcase
	end

	// weight and duty bound saturate at one
	always_comb begin
		cfg.target = target_q;
		cfg.kp     = $signed(kp_q);
		cfg.ki     = $signed(ki_q);
		cfg.kd     = $signed(kd_q);
		cfg.weight = (weight_q > UNITY) ? UNITY : weight_q;
		cfg.ilim   = ilim_q;
		cfg.dlim   = (dlim_q > UNITY) ? UNITY : dlim_q;
		cfg.tilt   = tilt_q;
	end

endmodule

@@ rtl/core/fptd_mac.sv @@
// shared signed multiply-accumulate unit of the tilt drive
module fptd_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fptd_pkg::mac_ctl_t                ctl,
	output logic signed [fptd_pkg::ACC_W-1:0] acc
);
	import fptd_pkg::*;

	localparam logic signed [ACC_W-1:0] ROUND_INIT = ACC_W'(1) <<< (FILT_FRAC - 1);

	logic                      en_s1;
	logic                      clr_s1;
	logic                      rnd_s1;
	logic                      hi_s1;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   base;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [ACC_W-1:0]   addend;

	always_ff @(posedge clk) begin
		prod_s1 <= $signed(ctl.a) * $signed(ctl.b);
	end

	always_comb begin
		base     = clr_s1 ? (rnd_s1 ? ROUND_INIT : '0) : acc_q;
		prod_ext = {{(ACC_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		addend   = hi_s1 ? (prod_ext <<< LO_W) : prod_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1  <= 1'b0;
			clr_s1 <= 1'b0;
			rnd_s1 <= 1'b0;
			hi_s1  <= 1'b0;
			acc_q  <= '0;
		end else begin
			en_s1  <= ctl.en;
			clr_s1 <= ctl.clr;
			rnd_s1 <= ctl.rnd;
			hi_s1  <= ctl.hi;
			if (en_s1) begin
				acc_q <= base + addend;
			end
		end
	end

	assign acc = acc_q;

endmodule

@@ rtl/core/fptd_seq.sv @@
// sequencer, loop state and result register of the tilt drive
`include "assert_macros.svh"

module fptd_seq #(
	parameter int SAMPLE_RATE_HZ = fptd_pkg::DEF_SAMPLE_RATE_HZ,
	parameter int SAMPLE_BITS    = fptd_pkg::DEF_SAMPLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fptd_pkg::cfg_t                    cfg,
	input  logic                              s_valid,
	output logic                              s_ready,
	input  logic [SAMPLE_BITS-1:0]            sample,
	output logic                              m_valid,
	input  logic                              m_ready,
	output logic [fptd_pkg::DUTY_W-1:0]       right,
	output logic [fptd_pkg::DUTY_W-1:0]       left,
	output logic                              cut,
	input  logic signed [fptd_pkg::ACC_W-1:0] acc,
	output fptd_pkg::mac_ctl_t                ctl
);
	import fptd_pkg::*;

	localparam int ANGLE_W = $bits(ANGLE_SCALE) + SAMPLE_BITS - ANGLE_SHIFT;
	localparam int IHI_W   = INTEG_W - LO_W;
	localparam int DHI_W   = DERIV_W - LO_W;
	localparam int DUTYX_W = ACC_W - FILT_FRAC;
	localparam logic [RATE_W-1:0]  RATE_HZ = RATE_W'(SAMPLE_RATE_HZ);
	localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((1 << LO_W) / SAMPLE_RATE_HZ);

	typedef enum logic [4:0] {
		ST_IDLE, ST_ANG, ST_ANG_W, ST_FLT1, ST_FLT2, ST_FLT_W, ST_ERR,
		ST_DQ, ST_DQ_W, ST_DC, ST_DC_W, ST_INTG, ST_DV_W, ST_DRV,
		ST_PI_P, ST_PI_IL, ST_PI_IH, ST_PI_DL, ST_PI_DH, ST_SUM_W, ST_OUT
	} state_t;

	state_t                    state_q;
	logic [SAMPLE_BITS-1:0]    sample_q;
	logic [FILT_W-1:0]         filt_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [ERR_W-1:0]   prev_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [DERIV_W-1:0] deriv_q;
	logic [ERR_W-1:0]          q0_q;
	logic                      m_valid_q;
	logic [DUTY_W-1:0]         right_q;
	logic [DUTY_W-1:0]         left_q;
	logic                      cut_q;

	logic [ANGLE_W-1:0]        angle;
	logic [FILT_W-1:0]         filt_new;
	logic signed [ERR_W-1:0]   err_new;
	logic [ERR_W-1:0]          mag;
	logic [ERR_W-1:0]          q0_acc;
	logic [ERR_W-1:0]          rem;
	logic [ERR_W-1:0]          q_fix;
	logic signed [ERR_W:0]     quot;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W:0]   ilim_pos;
	logic signed [INTEG_W:0]   integ_cl;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [DUTYX_W-1:0] duty;
	logic signed [DUTYX_W-1:0] dlim_ext;
	logic signed [DUTY_W:0]    duty_cl;
	logic signed [DUTY_W:0]    duty_neg;
	logic                      over_tilt;

	always_comb begin
		angle    = acc[ANGLE_SHIFT +: ANGLE_W];
		filt_new = acc[FILT_FRAC +: FILT_W];
		err_new  = $signed({{(ERR_W - TARGET_W){1'b0}}, cfg.target})
			- $signed({{(ERR_W - FILT_W){1'b0}}, filt_new});
		mag      = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
		q0_acc   = acc[LO_W +: ERR_W];

		// reciprocal estimate is low by at most one
		rem      = mag - acc[ERR_W-1:0];
		q_fix    = q0_q + ERR_W'(rem >= ERR_W'(RATE_HZ));
		quot     = err_q[ERR_W-1] ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});

		integ_sum = {integ_q[INTEG_W-1], integ_q}
			+ {{(INTEG_W - ERR_W){quot[ERR_W]}}, quot};
		ilim_pos  = $signed({2'b00, cfg.ilim});
		if (integ_sum > ilim_pos) begin
			integ_cl = ilim_pos;
		end else if (integ_sum < -ilim_pos) begin
			integ_cl = -ilim_pos;
		end else begin
			integ_cl = integ_sum;
		end

		diff = {err_q[ERR_W-1], err_q} - {prev_q[ERR_W-1], prev_q};

		// floor shift of the q32 sum to q16
		duty     = acc[ACC_W-1:FILT_FRAC];
		dlim_ext = $signed({{(DUTYX_W - DLIM_W){1'b0}}, cfg.dlim});
		if (duty > dlim_ext) begin
			duty_cl = (DUTY_W + 1)'(dlim_ext);
		end else if (duty < -dlim_ext) begin
			duty_cl = (DUTY_W + 1)'(-dlim_ext);
		end else begin
			duty_cl = (DUTY_W + 1)'(duty);
		end
		duty_neg  = -duty_cl;
		over_tilt = mag > ERR_W'(cfg.tilt);
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_ANG: begin
				ctl.en  = 1'b1;
				ctl.clr = 1'b1;
				ctl.a   = MUL_A_W'(sample_q);
				ctl.b   = MUL_B_W'(ANGLE_SCALE);
			end
			ST_FLT1: begin
				ctl.en  = 1'b1;
				ctl.clr = 1'b1;
				ctl.rnd = 1'b1;
				ctl.a   = MUL_A_W'(UNITY - cfg.weight);
				ctl.b   = MUL_B_W'(angle);
			end
			ST_FLT2: begin
				ctl.en = 1'b1;
				ctl.a  = MUL_A_W'(filt_q);
				ctl.b  = MUL_B_W'(cfg.weight);
			end
			ST_DQ: begin
				ctl.en  = 1'b1;
				ctl.clr = 1'b1;
				ctl.a   = MUL_A_W'(mag);
				ctl.b   = MUL_B_W'(RECIP);
			end
			ST_DC: begin
				ctl.en  = 1'b1;
				ctl.clr = 1'b1;
				ctl.a   = MUL_A_W'(q0_acc);
				ctl.b   = MUL_B_W'(RATE_HZ);
			end
			ST_INTG: begin
				ctl.en  = 1'b1;
				ctl.clr = 1'b1;
				ctl.a   = MUL_A_W'(diff);
				ctl.b   = MUL_B_W'(RATE_HZ);
			end
			ST_DRV: begin
				ctl.en  = 1'b1;
				ctl.clr = 1'b1;
				ctl.a   = {{(MUL_A_W - ERR_W){err_q[ERR_W-1]}}, err_q};
				ctl.b   = {{(MUL_B_W - GAIN_W){cfg.kp[GAIN_W-1]}}, cfg.kp};
			end
			ST_PI_IL: begin
				ctl.en = 1'b1;
				ctl.a  = {{(MUL_A_W - LO_W){1'b0}}, integ_q[LO_W-1:0]};
				ctl.b  = {{(MUL_B_W - GAIN_W){cfg.ki[GAIN_W-1]}}, cfg.ki};
			end
			ST_PI_IH: begin
				ctl.en = 1'b1;
				ctl.hi = 1'b1;
				ctl.a  = {{(MUL_A_W - IHI_W){integ_q[INTEG_W-1]}}, integ_q[INTEG_W-1:LO_W]};
				ctl.b  = {{(MUL_B_W - GAIN_W){cfg.ki[GAIN_W-1]}}, cfg.ki};
			end
			ST_PI_DL: begin
				ctl.en = 1'b1;
				ctl.a  = {{(MUL_A_W - LO_W){1'b0}}, deriv_q[LO_W-1:0]};
				ctl.b  = {{(MUL_B_W - GAIN_W){cfg.kd[GAIN_W-1]}}, cfg.kd};
			end
			ST_PI_DH: begin
				ctl.en = 1'b1;
				ctl.hi = 1'b1;
				ctl.a  = {{(MUL_A_W - DHI_W){deriv_q[DERIV_W-1]}}, deriv_q[DERIV_W-1:LO_W]};
				ctl.b  = {{(MUL_B_W - GAIN_W){cfg.kd[GAIN_W-1]}}, cfg.kd};
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sample_q  <= '0;
			filt_q    <= '0;
			err_q     <= '0;
			prev_q    <= '0;
			integ_q   <= '0;
			deriv_q   <= '0;
			q0_q      <= '0;
			m_valid_q <= 1'b0;
			right_q   <= '0;
			left_q    <= '0;
			cut_q     <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!m_valid_q || m_ready)) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_valid) begin
						sample_q <= sample;
						state_q  <= ST_ANG;
					end
				end
				ST_ANG:   state_q <= ST_ANG_W;
				ST_ANG_W: state_q <= ST_FLT1;
				ST_FLT1:  state_q <= ST_FLT2;
				ST_FLT2:  state_q <= ST_FLT_W;
				ST_FLT_W: state_q <= ST_ERR;
				ST_ERR: begin
					filt_q  <= filt_new;
					err_q   <= err_new;
					state_q <= ST_DQ;
				end
				ST_DQ:   state_q <= ST_DQ_W;
				ST_DQ_W: state_q <= ST_DC;
				ST_DC: begin
					q0_q    <= q0_acc;
					state_q <= ST_DC_W;
				end
				ST_DC_W: state_q <= ST_INTG;
				ST_INTG: begin
					integ_q <= INTEG_W'(integ_cl);
					state_q <= ST_DV_W;
				end
				ST_DV_W: state_q <= ST_DRV;
				ST_DRV: begin
					deriv_q <= acc[DERIV_W-1:0];
					prev_q  <= err_q;
					state_q <= ST_PI_IL;
				end
				ST_PI_P:  state_q <= ST_PI_IL;
				ST_PI_IL: state_q <= ST_PI_IH;
				ST_PI_IH: state_q <= ST_PI_DL;
				ST_PI_DL: state_q <= ST_PI_DH;
				ST_PI_DH: state_q <= ST_SUM_W;
				ST_SUM_W: state_q <= ST_OUT;
				ST_OUT: begin
					if (!m_valid_q || m_ready) begin
						cut_q     <= over_tilt;
						right_q   <= (over_tilt || duty_cl[DUTY_W]) ? '0 : duty_cl[DUTY_W-1:0];
						left_q    <= (over_tilt || !duty_cl[DUTY_W]) ? '0 : duty_neg[DUTY_W-1:0];
						state_q   <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign s_ready = (state_q == ST_IDLE);
	assign m_valid = m_valid_q;
	assign right   = right_q;
	assign left    = left_q;
	assign cut     = cut_q;

	`FPTD_ASSERT(a_accept_starts, clk, arst_n, (s_valid && s_ready) |=> (state_q == ST_ANG))
	`FPTD_ASSERT(a_stall_waits, clk, arst_n, (state_q == ST_OUT && m_valid_q && !m_ready) |=> (state_q == ST_OUT && m_valid_q))
	`FPTD_NEVER(a_both_sides, clk, arst_n, m_valid_q && right_q != '0 && left_q != '0)
	`FPTD_ASSERT(a_cut_zero, clk, arst_n, (m_valid_q && cut_q) |-> (right_q == '0 && left_q == '0))

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the filtered pid tilt drive with apb setup and streamed samples
module tb_top;
	import fptd_pkg::*;

	localparam int IN_W = ((DEF_SAMPLE_BITS + 7) / 8) * 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam longint ONE_Q16 = 65536;
	localparam longint RAD_PER_COUNT = 23827;
	localparam int REG_BITS [8] = '{TARGET_W, GAIN_W, GAIN_W, GAIN_W, WEIGHT_W, ILIM_W,
		DLIM_W, TILT_W};

	typedef struct {
		logic [DUTY_W-1:0] right;
		logic [DUTY_W-1:0] left;
		logic              cutoff;
	} drive_t;

	typedef logic [DATA_W-1:0] reg_set_t [8];

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [REG_ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0]     pwdata = '0;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;

	cfg_t              cfg_model;
	logic [FILT_W-1:0] filt_angle;
	longint            prev_err;
	longint            err_integral;
	logic [IN_W-1:0]   sample_q [$];
	logic [IN_W-1:0]   held_sample;
	drive_t            expected_drive_q [$];
	int                send_idle_pct;
	int                recv_idle_pct;
	int                mismatch_count = 0;
	int                quiet_cycles = 0;

	filtered_pid_tilt_drive dut (.*);

	always #5 clk = ~clk;

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0d, want %0d", what, got, want);
		mismatch_count++;
	endtask

	function automatic void predict_drive(logic [IN_W-1:0] raw);
		longint sample, angle, w, dlim, ilim, tilt, kp, ki, kd, tgt, fa;
		longint err, deriv, sum, duty, mag;
		drive_t d;
		sample = raw[DEF_SAMPLE_BITS-1:0];
		angle = (sample * RAD_PER_COUNT) >> 8;
		w = (cfg_model.weight > ONE_Q16) ? ONE_Q16 : cfg_model.weight;
		dlim = (cfg_model.dlim > ONE_Q16) ? ONE_Q16 : cfg_model.dlim;
		ilim = cfg_model.ilim;
		tilt = cfg_model.tilt;
		tgt = cfg_model.target;
		kp = {{40{cfg_model.kp[GAIN_W-1]}}, cfg_model.kp};
		ki = {{40{cfg_model.ki[GAIN_W-1]}}, cfg_model.ki};
		kd = {{40{cfg_model.kd[GAIN_W-1]}}, cfg_model.kd};
		fa = filt_angle;
		fa = (w * fa + (ONE_Q16 - w) * angle + 32768) >> 16;
		filt_angle = FILT_W'(fa);
		fa = filt_angle;
		err = tgt - fa;
		deriv = (err - prev_err) * DEF_SAMPLE_RATE_HZ;
		prev_err = err;
		err_integral += err / DEF_SAMPLE_RATE_HZ;
		if (err_integral > ilim) begin
			err_integral = ilim;
		end else if (err_integral < -ilim) begin
			err_integral = -ilim;
		end
		sum = err * kp + err_integral * ki + deriv * kd;
		duty = sum >>> 16;
		if (duty > dlim) begin
			duty = dlim;
		end else if (duty < -dlim) begin
			duty = -dlim;
		end
		mag = (err < 0) ? -err : err;
		d.right = '0;
		d.left = '0;
		d.cutoff = 1'b0;
		if (mag > tilt) begin
			d.cutoff = 1'b1;
		end else if (duty >= 0) begin
			d.right = DUTY_W'(duty);
		end else begin
			d.left = DUTY_W'(-duty);
		end
		expected_drive_q.push_back(d);
	endfunction

	// sample driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_drive(held_sample);
			end
			if (!s_tvalid || s_tready) begin
				if (sample_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					held_sample = sample_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= held_sample;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// drive monitor
	always @(posedge clk) begin : drive_monitor
		drive_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_drive_q.size() == 0) begin
					report_mismatch("unexpected item", m_tdata, 0);
				end else begin
					want = expected_drive_q.pop_front();
					if (m_tdata[DUTY_W-1:0] !== want.right) begin
						report_mismatch("drive_right", m_tdata[DUTY_W-1:0], want.right);
					end
					if (m_tdata[2*DUTY_W-1:DUTY_W] !== want.left) begin
						report_mismatch("drive_left", m_tdata[2*DUTY_W-1:DUTY_W], want.left);
					end
					if (m_tuser[0] !== want.cutoff) begin
						report_mismatch("tilt_cutoff", m_tuser[0], want.cutoff);
					end
				end
			end
			m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TARGET: cfg_model.target = value[TARGET_W-1:0];
			REG_KP:     cfg_model.kp = value[GAIN_W-1:0];
			REG_KI:     cfg_model.ki = value[GAIN_W-1:0];
			REG_KD:     cfg_model.kd = value[GAIN_W-1:0];
			REG_WEIGHT: cfg_model.weight = value[WEIGHT_W-1:0];
			REG_ILIM:   cfg_model.ilim = value[ILIM_W-1:0];
			REG_DLIM:   cfg_model.dlim = value[DLIM_W-1:0];
			REG_TILT:   cfg_model.tilt = value[TILT_W-1:0];
		endcase
	endtask

	task automatic apply_settings(reg_set_t v);
		for (int i = 0; i < 8; i++) begin
			write_reg(reg_idx_t'(i), v[i]);
		end
	endtask

	task automatic drain();
		do @(negedge clk);
		while (sample_q.size() != 0 || s_tvalid || expected_drive_q.size() != 0);
	endtask

	task automatic run_samples(logic [IN_W-1:0] list [$]);
		@(negedge clk);
		foreach (list[i]) begin
			sample_q.push_back(list[i]);
		end
		drain();
	endtask

	function automatic logic [DATA_W-1:0] with_noise(logic [DATA_W-1:0] v, int width);
		logic [DATA_W-1:0] keep;
		keep = (DATA_W'(1) << width) - DATA_W'(1);
		return (v & keep) | ($urandom() & ~keep);
	endfunction

	function automatic logic [DATA_W-1:0] rand_gain();
		longint g;
		case ($urandom_range(7, 0))
			0: g = 24'h7F_FFFF;
			1: g = -longint'(24'h80_0000);
			default: begin
				g = $urandom() >> $urandom_range(31, 9);
				if ($urandom_range(1, 0)) begin
					g = -g;
				end
			end
		endcase
		return g[DATA_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] rand_unit();
		case ($urandom_range(3, 0))
			0: return 0;
			1: return DATA_W'(ONE_Q16);
			2: return $urandom_range(65536, 0);
			default: return $urandom_range(131071, 65537);
		endcase
	endfunction

	task automatic random_settings();
		reg_set_t v;
		v[REG_TARGET] = $urandom_range(381160, 0);
		v[REG_KP] = rand_gain();
		v[REG_KI] = rand_gain();
		v[REG_KD] = rand_gain();
		v[REG_WEIGHT] = rand_unit();
		case ($urandom_range(2, 0))
			0: v[REG_ILIM] = $urandom();
			1: v[REG_ILIM] = $urandom_range(2000000, 0);
			default: v[REG_ILIM] = 0;
		endcase
		v[REG_DLIM] = rand_unit();
		v[REG_TILT] = ($urandom_range(3, 0) == 0) ? $urandom_range(524287, 0)
			: $urandom_range(411775, 20000);
		for (int i = 0; i < 8; i++) begin
			v[i] = with_noise(v[i], REG_BITS[i]);
		end
		apply_settings(v);
	endtask

	// mostly samples around the set-point so the loop stays out of cutoff
	task automatic run_random(int count);
		logic [IN_W-1:0] list [$];
		int center, pick;
		center = int'((longint'(cfg_model.target) * 256) / RAD_PER_COUNT);
		repeat (count) begin
			case ($urandom_range(9, 0))
				0, 1, 2, 3, 4, 5: begin
					pick = center + $urandom_range(80, 0) - 40;
					pick = (pick < 0) ? 0 : (pick > 4095) ? 4095 : pick;
					list.push_back(IN_W'(pick));
				end
				6, 7, 8: list.push_back(IN_W'($urandom_range(4095, 0)));
				default: list.push_back(IN_W'($urandom()));
			endcase
		end
		run_samples(list);
	endtask

	initial begin
		cfg_model = '{target: TARGET_RST, kp: GAIN_RST, ki: GAIN_RST, kd: GAIN_RST,
			weight: WEIGHT_RST, ilim: ILIM_RST, dlim: DLIM_RST, tilt: TILT_RST};
		filt_angle = '0;
		prev_err = 0;
		err_integral = 0;
		send_idle_pct = 23;
		recv_idle_pct = 57;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, sample extremes and bits above the sample width
		run_samples('{16'd0, 16'd4095, 16'hFFFF, 16'hF000});
		// full-scale proportional and integral gains, oversized words, no filtering, zero integral bound
		apply_settings('{32'hFFFF_FFFF, 32'h007F_FFFF, 32'h0080_0000, 32'h0000_0100,
			32'd0, 32'd0, 32'd65536, 32'hFFFF_FFFF});
		run_samples('{16'd0, 16'd4095, 16'd0, 16'd4095, 16'd2048});
		// weight and duty limit above one, zero tilt limit
		apply_settings('{32'd190000, 32'h0000_A000, 32'h00FF_0000, 32'h00FF_FF00,
			32'h0001_FFFF, 32'd100, 32'h0001_FFFF, 32'd0});
		run_samples('{16'd100, 16'd3000, 16'd2041});
		write_reg(REG_WEIGHT, 32'd65536);
		write_reg(REG_DLIM, 32'd0);
		write_reg(REG_TILT, 32'd411775);
		run_samples('{16'd0, 16'd4095});
		apply_settings('{32'd381160, 32'h0001_0000, 32'h0000_0100, 32'h0000_0001,
			32'd32768, 32'hFFFF_FFFF, 32'd300, 32'd411775});
		run_samples('{16'd4095, 16'd4094, 16'd4095, 16'd4095, 16'd4000, 16'd0});

		for (int regime = 0; regime < 3; regime++) begin
			send_idle_pct = (regime == 0) ? 23 : (regime == 1) ? 57 : 0;
			recv_idle_pct = (regime == 0) ? 57 : (regime == 1) ? 23 : 0;
			repeat (5) begin
				random_settings();
				run_random(110);
			end
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/fptd_pkg.sv
rtl/core/fptd_regs.sv
rtl/core/fptd_mac.sv
rtl/core/fptd_seq.sv
rtl/core/filtered_pid_tilt_drive.sv
test/tb_top.sv
